### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds whenever the antecedent does.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### src/fbpm_pkg.sv
// ----------------------------------------------------------------------------
// fbpm_pkg
// Types and constants shared by the frame buffer pool manager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpm_pkg;

    // Default number of buffers in the pool.
    localparam int POOL_BUFFERS_DEF = 4;

    // Action codes of a request.
    localparam logic [2:0] ACT_PAINT      = 3'd0;
    localparam logic [2:0] ACT_CONSUME    = 3'd1;
    localparam logic [2:0] ACT_RETURN     = 3'd2;
    localparam logic [2:0] ACT_CLEAR_PEND = 3'd3;
    localparam logic [2:0] ACT_RESET_POOL = 3'd4;

    // One request item.
    typedef struct packed {
        logic [2:0]  action;
        logic [14:0] frame_width;
        logic [14:0] frame_height;
        logic [1:0]  buffer_index;
    } fbpm_req_t;

    // One result item.
    typedef struct packed {
        logic        accepted;
        logic [1:0]  buffer_index_res;
        logic [31:0] generation;
        logic        replaced_ready;
        logic        reinitialized;
        logic [2:0]  free_count;
        logic        ready_valid;
        logic [2:0]  in_flight_count;
        logic        fresh_pending;
    } fbpm_res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic search;
        logic commit;
    } fbpm_cmd_t;

endpackage

`default_nettype wire

### src/fbpm_ctrl.sv
// ----------------------------------------------------------------------------
// fbpm_ctrl
// Sequencer that walks each request through a search state and a commit state.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpm_ctrl
    import fbpm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    output fbpm_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_UPDATE = 3'b100
    } fbpm_state_t;

    fbpm_state_t state_reg;
    fbpm_state_t state_next;
    logic        take;

    // A new request can be taken in idle and while the previous one commits.
    assign busy = (state_reg == ST_SEARCH);
    assign take = start && !busy;

    // Next-state logic.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = take ? ST_SEARCH : ST_IDLE;
            ST_SEARCH: state_next = ST_UPDATE;
            ST_UPDATE: state_next = take ? ST_SEARCH : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath commands.
    assign cmd.load   = take;
    assign cmd.search = (state_reg == ST_SEARCH);
    assign cmd.commit = (state_reg == ST_UPDATE);

endmodule

`default_nettype wire

### src/fbpm_datapath.sv
// ----------------------------------------------------------------------------
// fbpm_datapath
// Pool state, list searches and the per-request state update.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpm_datapath
    import fbpm_pkg::*;
#(
    parameter int POOL_BUFFERS = POOL_BUFFERS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire fbpm_cmd_t cmd,
    input  wire fbpm_req_t request,
    output logic           done,
    output fbpm_res_t      result
);

    localparam int SLOT_W = (POOL_BUFFERS > 1) ? $clog2(POOL_BUFFERS) : 1;
    localparam int CNT_W  = $clog2(POOL_BUFFERS + 1);
    localparam int IDX_W  = SLOT_W + 2;
    localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_BUFFERS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_BUFFERS - 1);
    localparam logic [IDX_W-1:0]  POOL_IDX  = IDX_W'(POOL_BUFFERS);

    // Pool state.
    logic [SLOT_W-1:0] free_stack_reg  [POOL_BUFFERS];
    logic [SLOT_W-1:0] free_stack_next [POOL_BUFFERS];
    logic [SLOT_W-1:0] flight_list_reg [POOL_BUFFERS];
    logic [SLOT_W-1:0] flight_list_next[POOL_BUFFERS];
    logic [31:0]       slot_gen_reg    [POOL_BUFFERS];
    logic [31:0]       slot_gen_next   [POOL_BUFFERS];
    logic [CNT_W-1:0]  free_top_reg,     free_top_next;
    logic [CNT_W-1:0]  flight_count_reg, flight_count_next;
    logic              ready_flag_reg,   ready_flag_next;
    logic [SLOT_W-1:0] ready_slot_reg,   ready_slot_next;
    logic [31:0]       paint_gen_reg,    paint_gen_next;
    logic [31:0]       uploaded_gen_reg, uploaded_gen_next;
    logic [14:0]       alloc_width_reg,  alloc_width_next;
    logic [14:0]       alloc_height_reg, alloc_height_next;

    // Captured request and search results.
    fbpm_req_t         req_reg;
    logic [SLOT_W-1:0] pop_entry_reg;
    logic              ready_hit_reg;
    logic              idx_hit_reg;
    logic              fl_hit_reg;
    logic [SLOT_W-1:0] fl_pos_reg;
    logic [SLOT_W-1:0] fl_last_reg;
    logic [31:0]       ready_gen_reg;
    logic              gen_gt_reg;
    logic              size_diff_reg;

    // Result register.
    fbpm_res_t         result_reg;
    fbpm_res_t         result_next;
    logic              done_reg;

    logic [CNT_W-1:0]  top_m1;
    logic [CNT_W-1:0]  fl_m1;
    logic [IDX_W-1:0]  idx_wide;
    logic [SLOT_W-1:0] idx_slot;
    logic              idx_ok;
    logic              ready_hit;
    logic              idx_hit;
    logic              fl_hit;
    logic [SLOT_W-1:0] fl_pos;
    logic [CNT_W+2:0]  free_wide;
    logic [CNT_W+2:0]  flight_wide;
    logic [SLOT_W+1:0] grant_wide;
    logic [SLOT_W-1:0] grant_slot;
    logic              grant;
    logic              replaced;
    logic              reinit;
    logic [31:0]       grant_gen;

    assign top_m1   = free_top_reg - CNT_W'(1);
    assign fl_m1    = flight_count_reg - CNT_W'(1);
    assign idx_wide = {{SLOT_W{1'b0}}, req_reg.buffer_index};
    assign idx_slot = idx_wide[SLOT_W-1:0];
    assign idx_ok   = (idx_wide < POOL_IDX);

    // Membership searches over the free stack and the flight list.
    always_comb
    begin
        ready_hit = 1'b0;
        idx_hit   = 1'b0;
        fl_hit    = 1'b0;
        fl_pos    = '0;
        for (int i = 0; i < POOL_BUFFERS; i++)
        begin
            if ((CNT_W'(i) < top_m1) && (free_stack_reg[i] == ready_slot_reg))
            begin
                ready_hit = 1'b1;
            end
            if ((CNT_W'(i) < free_top_reg) && (free_stack_reg[i] == idx_slot))
            begin
                idx_hit = 1'b1;
            end
        end
        // Scan downward so that the lowest matching position wins.
        for (int i = POOL_BUFFERS - 1; i >= 0; i--)
        begin
            if ((CNT_W'(i) < flight_count_reg) && (flight_list_reg[i] == idx_slot))
            begin
                fl_hit = 1'b1;
                fl_pos = SLOT_W'(i);
            end
        end
    end

    // Request capture and search result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.search)
        begin
            pop_entry_reg <= free_stack_reg[top_m1[SLOT_W-1:0]];
            ready_hit_reg <= ready_hit;
            idx_hit_reg   <= idx_hit;
            fl_hit_reg    <= fl_hit;
            fl_pos_reg    <= fl_pos;
            fl_last_reg   <= flight_list_reg[fl_m1[SLOT_W-1:0]];
            ready_gen_reg <= slot_gen_reg[ready_slot_reg];
            gen_gt_reg    <= (paint_gen_reg > uploaded_gen_reg);
            size_diff_reg <= (req_reg.frame_width != alloc_width_reg) ||
                             (req_reg.frame_height != alloc_height_reg);
        end
    end

    // State update for the request being committed.
    always_comb
    begin
        free_stack_next   = free_stack_reg;
        flight_list_next  = flight_list_reg;
        slot_gen_next     = slot_gen_reg;
        free_top_next     = free_top_reg;
        flight_count_next = flight_count_reg;
        ready_flag_next   = ready_flag_reg;
        ready_slot_next   = ready_slot_reg;
        paint_gen_next    = paint_gen_reg;
        uploaded_gen_next = uploaded_gen_reg;
        alloc_width_next  = alloc_width_reg;
        alloc_height_next = alloc_height_reg;
        grant             = 1'b0;
        grant_slot        = '0;
        grant_gen         = '0;
        replaced          = 1'b0;
        reinit            = 1'b0;

        case (req_reg.action)
            ACT_PAINT:
            begin
                if (size_diff_reg)
                begin
                    // Rebuild, then pop the top buffer of the refilled stack.
                    for (int i = 0; i < POOL_BUFFERS; i++)
                    begin
                        free_stack_next[i] = SLOT_W'(i);
                        slot_gen_next[i]   = '0;
                    end
                    slot_gen_next[LAST_SLOT] = 32'd1;
                    free_top_next     = POOL_CNT - CNT_W'(1);
                    flight_count_next = '0;
                    ready_flag_next   = 1'b1;
                    ready_slot_next   = LAST_SLOT;
                    paint_gen_next    = 32'd1;
                    uploaded_gen_next = '0;
                    alloc_width_next  = req_reg.frame_width;
                    alloc_height_next = req_reg.frame_height;
                    grant             = 1'b1;
                    grant_slot        = LAST_SLOT;
                    grant_gen         = 32'd1;
                    reinit            = 1'b1;
                end
                else
                begin
                    if (free_top_reg != '0)
                    begin
                        grant         = 1'b1;
                        grant_slot    = pop_entry_reg;
                        free_top_next = top_m1;
                        // The older ready buffer goes back unless already free.
                        if (ready_flag_reg)
                        begin
                            replaced = 1'b1;
                            if (!ready_hit_reg)
                            begin
                                free_stack_next[top_m1[SLOT_W-1:0]] = ready_slot_reg;
                                free_top_next = free_top_reg;
                            end
                        end
                    end
                    else if (ready_flag_reg)
                    begin
                        // Recycle the unconsumed ready buffer.
                        grant      = 1'b1;
                        grant_slot = ready_slot_reg;
                        replaced   = 1'b1;
                    end
                    if (grant)
                    begin
                        paint_gen_next            = paint_gen_reg + 32'd1;
                        slot_gen_next[grant_slot] = paint_gen_reg + 32'd1;
                        ready_flag_next           = 1'b1;
                        ready_slot_next           = grant_slot;
                        grant_gen                 = paint_gen_reg + 32'd1;
                    end
                end
            end
            ACT_CONSUME:
            begin
                if (ready_flag_reg && gen_gt_reg)
                begin
                    grant           = 1'b1;
                    grant_slot      = ready_slot_reg;
                    grant_gen       = ready_gen_reg;
                    ready_flag_next = 1'b0;
                    uploaded_gen_next = ready_gen_reg;
                    if (flight_count_reg < POOL_CNT)
                    begin
                        flight_list_next[flight_count_reg[SLOT_W-1:0]] = ready_slot_reg;
                        flight_count_next = flight_count_reg + CNT_W'(1);
                    end
                end
            end
            ACT_RETURN:
            begin
                if (idx_ok)
                begin
                    slot_gen_next[idx_slot] = '0;
                    // Remove from flight by moving the last entry into the hole.
                    if (fl_hit_reg)
                    begin
                        flight_count_next          = fl_m1;
                        flight_list_next[fl_pos_reg] = fl_last_reg;
                    end
                    if (!idx_hit_reg && (free_top_reg < POOL_CNT))
                    begin
                        free_stack_next[free_top_reg[SLOT_W-1:0]] = idx_slot;
                        free_top_next = free_top_reg + CNT_W'(1);
                    end
                end
            end
            ACT_CLEAR_PEND:
            begin
                uploaded_gen_next = paint_gen_reg;
            end
            ACT_RESET_POOL:
            begin
                for (int i = 0; i < POOL_BUFFERS; i++)
                begin
                    slot_gen_next[i] = '0;
                end
                free_top_next     = '0;
                flight_count_next = '0;
                ready_flag_next   = 1'b0;
                ready_slot_next   = '0;
                paint_gen_next    = '0;
                uploaded_gen_next = '0;
                alloc_width_next  = '0;
                alloc_height_next = '0;
            end
            default:
            begin
                // Unused actions only report status.
            end
        endcase
    end

    // Result assembly from the updated state.
    assign free_wide   = {3'b000, free_top_next};
    assign flight_wide = {3'b000, flight_count_next};
    assign grant_wide  = {2'b00, grant_slot};

    always_comb
    begin
        result_next.accepted         = grant;
        result_next.buffer_index_res = grant ? grant_wide[1:0] : 2'b00;
        result_next.generation       = grant_gen;
        result_next.replaced_ready   = replaced;
        result_next.reinitialized    = reinit;
        result_next.free_count       = free_wide[2:0];
        result_next.ready_valid      = ready_flag_next;
        result_next.in_flight_count  = flight_wide[2:0];
        result_next.fresh_pending    = ready_flag_next &&
                                       (paint_gen_next > uploaded_gen_next);
    end

    // Control state with defined reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg     <= '0;
            flight_count_reg <= '0;
            ready_flag_reg   <= 1'b0;
            ready_slot_reg   <= '0;
            paint_gen_reg    <= '0;
            uploaded_gen_reg <= '0;
            alloc_width_reg  <= '0;
            alloc_height_reg <= '0;
            for (int i = 0; i < POOL_BUFFERS; i++)
            begin
                slot_gen_reg[i] <= '0;
            end
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.commit)
            begin
                free_top_reg     <= free_top_next;
                flight_count_reg <= flight_count_next;
                ready_flag_reg   <= ready_flag_next;
                ready_slot_reg   <= ready_slot_next;
                paint_gen_reg    <= paint_gen_next;
                uploaded_gen_reg <= uploaded_gen_next;
                alloc_width_reg  <= alloc_width_next;
                alloc_height_reg <= alloc_height_next;
                slot_gen_reg     <= slot_gen_next;
            end
        end
    end

    // List contents and the result payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            free_stack_reg  <= free_stack_next;
            flight_list_reg <= flight_list_next;
            result_reg      <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### src/frame_buffer_pool_manager_top.sv
// ----------------------------------------------------------------------------
// frame_buffer_pool_manager_top
// Latest-frame-wins pool of frame buffers: paint, consume and return events.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload      Transfer when
//  -------   ---------------------   ----------   -------------------------
//  request   start in / busy out     fbpm_req_t   start high and busy low
//  result    done out (strobe)       fbpm_res_t   every cycle done is high
//
//  Each request passes through a search state and a commit state; its result
//  is registered at the commit and flagged by done. A new request can be
//  taken while the previous one commits: busy is high only in the search
//  state, where the list scans and dynamic reads are registered.
//  Reset clears the pool to empty and unallocated at once; no clearing pass.
//  The result side cannot stall; a result is lost if not taken.
//
`default_nettype none

`include "assert_macros.svh"

module frame_buffer_pool_manager_top
    import fbpm_pkg::*;
#(
    parameter int POOL_BUFFERS = POOL_BUFFERS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire fbpm_req_t request,
    output logic           done,
    output fbpm_res_t      result
);

    fbpm_cmd_t cmd;

    // Sequencer.
    fbpm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Pool state and update logic.
    fbpm_datapath #(
        .POOL_BUFFERS (POOL_BUFFERS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Every transfer is followed by its result.
    `ASSERT_IMPL(a_result_follows, clk, rst_n, start && !busy, ##3 done, "missing result")
    // A result only follows a search.
    `ASSERT_IMPL(a_result_origin, clk, rst_n, done, $past(busy, 2), "unexpected result")
    // Busy is always low in the cycle after it is high.
    `ASSERT_IMPL(a_search_once, clk, rst_n, busy, ##1 !busy, "search phase stuck")
    // A rebuild always grants the first generation.
    `ASSERT_IMPL(a_rebuild_gen, clk, rst_n, done && result.reinitialized,
        result.accepted && (result.generation == 32'd1), "bad rebuild grant")

endmodule

`default_nettype wire

### tb/tb_frame_buffer_pool_manager_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_buffer_pool_manager_top
// Self-checking bench for the frame buffer pool manager. Paint, consume,
// return, clear and pool reset events go in through the start/busy command
// port. Each transfer is run through a behavioral pool model that keeps its
// own free stack, flight list and generation counters. Every done strobe is
// checked against the oldest predicted status. Directed tests walk the
// corner cases, and three random phases follow, each with its own
// start-idling rate.
// ----------------------------------------------------------------------------
module tb_frame_buffer_pool_manager_top;
    import fbpm_pkg::*;

    localparam int         NBUF          = POOL_BUFFERS_DEF;
    localparam logic [2:0] ACT_LAST      = 3'd7;
    localparam int         REPORT_LIMIT  = 10;
    localparam int         SETTLE_CYCLES = 8;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    fbpm_req_t request;
    logic      done;
    fbpm_res_t result;

    // Status words still owed by the block, oldest first.
    fbpm_res_t pending_status[$];
    int        error_count;
    int        start_idle_pct;

    // Behavioral copy of the pool.
    logic [1:0]  pool_free_stack [NBUF];
    logic [2:0]  pool_free_top;
    logic        pool_ready;
    logic [1:0]  pool_ready_slot;
    logic [1:0]  pool_flight [NBUF];
    logic [2:0]  pool_flight_cnt;
    logic [31:0] pool_paint_gen;
    logic [31:0] pool_upload_gen;
    logic [31:0] pool_slot_gen [NBUF];
    logic [14:0] pool_alloc_w;
    logic [14:0] pool_alloc_h;

    frame_buffer_pool_manager_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Empty, unallocated pool.
    function automatic void pool_clear();
        for (int i = 0; i < NBUF; i++)
        begin
            pool_free_stack[i] = '0;
            pool_flight[i]     = '0;
            pool_slot_gen[i]   = '0;
        end
        pool_free_top   = '0;
        pool_ready      = 1'b0;
        pool_ready_slot = '0;
        pool_flight_cnt = '0;
        pool_paint_gen  = '0;
        pool_upload_gen = '0;
        pool_alloc_w    = '0;
        pool_alloc_h    = '0;
    endfunction

    // Push a buffer onto the free stack unless it is already there or the
    // stack is full.
    function automatic void release_to_free(logic [1:0] buf_id);
        logic present;
        present = 1'b0;
        for (int i = 0; i < NBUF; i++)
            if (i < pool_free_top && pool_free_stack[i] == buf_id)
                present = 1'b1;
        if (!present && pool_free_top < NBUF)
        begin
            pool_free_stack[pool_free_top[1:0]] = buf_id;
            pool_free_top = pool_free_top + 3'd1;
        end
    endfunction

    // Apply one event to the pool model and return the status it reports.
    function automatic fbpm_res_t predict_pool_event(fbpm_req_t ev);
        fbpm_res_t  r;
        logic [1:0] b;
        logic       found;
        r     = '0;
        b     = '0;
        found = 1'b0;
        case (ev.action)
            ACT_PAINT:
            begin
                // A new frame size rebuilds the whole pool.
                if (ev.frame_width != pool_alloc_w || ev.frame_height != pool_alloc_h)
                begin
                    for (int i = 0; i < NBUF; i++)
                    begin
                        pool_free_stack[i] = 2'(i);
                        pool_slot_gen[i]   = '0;
                    end
                    pool_free_top   = 3'(NBUF);
                    pool_ready      = 1'b0;
                    pool_ready_slot = '0;
                    pool_flight_cnt = '0;
                    pool_alloc_w    = ev.frame_width;
                    pool_alloc_h    = ev.frame_height;
                    pool_paint_gen  = '0;
                    pool_upload_gen = '0;
                    r.reinitialized = 1'b1;
                end
                // Free buffer first, then the unconsumed ready one.
                if (pool_free_top > 0)
                begin
                    pool_free_top = pool_free_top - 3'd1;
                    b = pool_free_stack[pool_free_top[1:0]];
                    r.accepted = 1'b1;
                end
                else if (pool_ready)
                begin
                    b = pool_ready_slot;
                    pool_ready = 1'b0;
                    r.replaced_ready = 1'b1;
                    r.accepted = 1'b1;
                end
                if (r.accepted)
                begin
                    pool_paint_gen   = pool_paint_gen + 32'd1;
                    pool_slot_gen[b] = pool_paint_gen;
                    if (pool_ready)
                    begin
                        release_to_free(pool_ready_slot);
                        r.replaced_ready = 1'b1;
                    end
                    pool_ready         = 1'b1;
                    pool_ready_slot    = b;
                    r.buffer_index_res = b;
                    r.generation       = pool_paint_gen;
                end
            end
            ACT_CONSUME:
            begin
                if (pool_ready && pool_paint_gen > pool_upload_gen)
                begin
                    b = pool_ready_slot;
                    pool_ready = 1'b0;
                    // A full flight list still hands the buffer out.
                    if (pool_flight_cnt < NBUF)
                    begin
                        pool_flight[pool_flight_cnt[1:0]] = b;
                        pool_flight_cnt = pool_flight_cnt + 3'd1;
                    end
                    pool_upload_gen    = pool_slot_gen[b];
                    r.accepted         = 1'b1;
                    r.buffer_index_res = b;
                    r.generation       = pool_slot_gen[b];
                end
            end
            ACT_RETURN:
            begin
                pool_slot_gen[ev.buffer_index] = '0;
                for (int i = 0; i < NBUF; i++)
                begin
                    if (!found && i < pool_flight_cnt && pool_flight[i] == ev.buffer_index)
                    begin
                        pool_flight_cnt = pool_flight_cnt - 3'd1;
                        pool_flight[i]  = pool_flight[pool_flight_cnt[1:0]];
                        found = 1'b1;
                    end
                end
                release_to_free(ev.buffer_index);
            end
            ACT_CLEAR_PEND: pool_upload_gen = pool_paint_gen;
            ACT_RESET_POOL: pool_clear();
            default: ;
        endcase
        r.free_count      = pool_free_top;
        r.ready_valid     = pool_ready;
        r.in_flight_count = pool_flight_cnt;
        r.fresh_pending   = pool_ready && (pool_paint_gen > pool_upload_gen);
        return r;
    endfunction

    function automatic fbpm_req_t make_event(logic [2:0] act, logic [14:0] w,
                                             logic [14:0] h, logic [1:0] idx);
        fbpm_req_t ev;
        ev.action       = act;
        ev.frame_width  = w;
        ev.frame_height = h;
        ev.buffer_index = idx;
        return ev;
    endfunction

    function automatic string format_status(fbpm_res_t s);
        return $sformatf({"acc=%0d idx=%0d gen=%0d repl=%0d reinit=%0d ",
                          "free=%0d rdy=%0d fl=%0d fresh=%0d"},
                         s.accepted, s.buffer_index_res, s.generation, s.replaced_ready,
                         s.reinitialized, s.free_count, s.ready_valid, s.in_flight_count,
                         s.fresh_pending);
    endfunction

    // Send one event. In every cycle the start line idles with the phase's
    // probability. Start is left high so that back-to-back events keep it
    // asserted.
    task automatic send_event(input fbpm_req_t ev);
        logic offer;
        offer   = 1'b0;
        request <= ev;
        do
        begin
            offer = ($urandom_range(99) >= start_idle_pct);
            start <= offer;
            @(posedge clk);
        end
        while (!offer || busy);
        pending_status.push_back(predict_pool_event(ev));
    endtask

    // Hold off new events until every owed status has arrived.
    task automatic wait_for_status_drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    // Result checker: each strobe is matched against the oldest prediction.
    always @(posedge clk)
    begin
        fbpm_res_t want;
        if (rst_n && done)
        begin
            if (pending_status.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected status %s", $realtime, format_status(result));
            end
            else
            begin
                want = pending_status.pop_front();
                if (result.accepted !== want.accepted
                    || result.buffer_index_res !== want.buffer_index_res
                    || result.generation !== want.generation
                    || result.replaced_ready !== want.replaced_ready
                    || result.reinitialized !== want.reinitialized
                    || result.free_count !== want.free_count
                    || result.ready_valid !== want.ready_valid
                    || result.in_flight_count !== want.in_flight_count
                    || result.fresh_pending !== want.fresh_pending)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: status mismatch", $realtime);
                        $display("  expected %s", format_status(want));
                        $display("  actual   %s", format_status(result));
                    end
                end
            end
        end
    end

    // Unallocated pool: 0x0 paint that neither rebuilds nor gets a buffer,
    // stale consume, and the unused action codes.
    task automatic test_empty_pool();
        send_event(make_event(ACT_PAINT, 15'd0, 15'd0, 2'd0));
        send_event(make_event(ACT_CONSUME, 15'h7FFF, 15'h7FFF, 2'd3));
        for (logic [3:0] a = {1'b0, ACT_RESET_POOL} + 4'd1; a <= {1'b0, ACT_LAST}; a++)
            send_event(make_event(a[2:0], 15'h7FFF, 15'd0, 2'd3));
    endtask

    // Drain the free stack, fill the flight list, consume with the list
    // full, drop a paint, recycle and release ready buffers, and return
    // buffers both in and out of flight.
    task automatic test_pool_exhaustion();
        for (int i = 0; i < 3; i++)
        begin
            send_event(make_event(ACT_PAINT, 15'd1920, 15'd1080, 2'd0));
            send_event(make_event(ACT_CONSUME, 15'd0, 15'd0, 2'd0));
        end
        send_event(make_event(ACT_PAINT, 15'd1920, 15'd1080, 2'd0));
        send_event(make_event(ACT_RETURN, 15'd0, 15'd0, 2'd0));
        send_event(make_event(ACT_CONSUME, 15'd0, 15'd0, 2'd0));
        send_event(make_event(ACT_PAINT, 15'd1920, 15'd1080, 2'd0));
        send_event(make_event(ACT_CONSUME, 15'd0, 15'd0, 2'd0));
        send_event(make_event(ACT_PAINT, 15'd1920, 15'd1080, 2'd0));
        send_event(make_event(ACT_RETURN, 15'd0, 15'd0, 2'd2));
        send_event(make_event(ACT_PAINT, 15'd1920, 15'd1080, 2'd0));
        send_event(make_event(ACT_PAINT, 15'd1920, 15'd1080, 2'd0));
        send_event(make_event(ACT_RETURN, 15'd0, 15'd0, 2'd1));
        send_event(make_event(ACT_PAINT, 15'd1920, 15'd1080, 2'd0));
        send_event(make_event(ACT_RETURN, 15'd0, 15'd0, 2'd3));
        send_event(make_event(ACT_RETURN, 15'd0, 15'd0, 2'd3));
        send_event(make_event(ACT_CLEAR_PEND, 15'd0, 15'd0, 2'd0));
        send_event(make_event(ACT_CONSUME, 15'd0, 15'd0, 2'd0));
    endtask

    // Frame size extremes and the pool reset action.
    task automatic test_size_changes();
        send_event(make_event(ACT_PAINT, 15'h7FFF, 15'h7FFF, 2'd0));
        send_event(make_event(ACT_PAINT, 15'd16384, 15'd0, 2'd0));
        send_event(make_event(ACT_RESET_POOL, 15'd0, 15'd0, 2'd0));
        send_event(make_event(ACT_PAINT, 15'd0, 15'd0, 2'd0));
    endtask

    // Mostly well-formed frame traffic at a stable size, with occasional
    // size changes and fully random events mixed in.
    task automatic test_random_traffic(input int count, input int idle_pct);
        fbpm_req_t   ev;
        logic [14:0] cur_w;
        logic [14:0] cur_h;
        int          pick;
        start_idle_pct = idle_pct;
        cur_w = 15'd640;
        cur_h = 15'd480;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 3)
            begin
                case ($urandom_range(3))
                    0: begin cur_w = 15'd640;   cur_h = 15'd480;   end
                    1: begin cur_w = 15'd1920;  cur_h = 15'd1080;  end
                    2: begin cur_w = 15'd1;     cur_h = 15'd1;     end
                    default: begin cur_w = 15'd16384; cur_h = 15'd16384; end
                endcase
            end
            ev = make_event(ACT_PAINT, 15'($urandom), 15'($urandom), 2'($urandom));
            pick = $urandom_range(99);
            if (pick < 36)
            begin
                ev.frame_width  = cur_w;
                ev.frame_height = cur_h;
            end
            else if (pick < 66)
                ev.action = ACT_CONSUME;
            else if (pick < 90)
            begin
                ev.action = ACT_RETURN;
                // Usually return something that is really in flight.
                if (pool_flight_cnt > 0 && $urandom_range(99) < 70)
                    ev.buffer_index =
                        pool_flight[2'($urandom_range(pool_flight_cnt - 3'd1))];
            end
            else if (pick < 94)
                ev.action = ACT_CLEAR_PEND;
            else if (pick < 96)
                ev.action = ACT_RESET_POOL;
            else
                ev.action = 3'($urandom_range(ACT_LAST));
            send_event(ev);
        end
    endtask

    // Reset, tests in turn, drain and verdict.
    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        error_count    = 0;
        start_idle_pct = 0;
        pool_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pool();
        test_pool_exhaustion();
        test_size_changes();
        wait_for_status_drain();

        test_random_traffic(320, 38);
        wait_for_status_drain();
        test_random_traffic(320, 71);
        test_random_traffic(300, 0);
        wait_for_status_drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_status.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
